// ===== src/lru_keyed_entry_cache_defines.svh =====
// assertion helpers for the keyed entry cache
`ifndef LRU_KEYED_ENTRY_CACHE_DEFINES_SVH
`define LRU_KEYED_ENTRY_CACHE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LKC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LKC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lkc_pkg.sv =====
`default_nettype none

package lkc_pkg;

    localparam int DEF_CAPACITY = 16;

    localparam int KEY_W  = 64;
    localparam int SIZE_W = 32;
    localparam int SLOT_W = 4;

    // stream widths, fields packed from bit 0, tdata padded to whole bytes
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 104;
    localparam int M_TUSER_W = 2;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } t_op;

endpackage

`default_nettype wire

// ===== src/lru_keyed_entry_cache.sv =====
`default_nettype none
`include "lru_keyed_entry_cache_defines.svh"

// channel   dir   tdata (low bit first)                      tuser
// s_axis    in    key[63:0], entry_size[95:64]               operation[0]
// m_axis    out   slot[3:0], stored_size[35:4],              hit[0], evicted[1]
//                 evicted_key[99:36], zero pad[103:100]
//
// one request at a time: a hit or an insert takes two passes over the slot
// memories, one slot a cycle, and a lookup miss only the first of them:
// a search pass through key/size/rank and an aging pass rewriting ranks
// reset (synchronous, active low) clears valid bits, fill count and handshake
// state; slot memories need no clearing pass
// a result held on a stalled m_axis blocks only the end of the next request

module lru_keyed_entry_cache
    import lkc_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // key, entry_size
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,   // operation

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,   // slot, stored_size, evicted_key
    output logic [M_TUSER_W-1:0]      m_axis_tuser    // hit, evicted
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);
    localparam int PAD_W = M_TDATA_W - SLOT_W - SIZE_W - KEY_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,    // search pass: match / victim / first free
        ST_AGE,     // rank update pass
        ST_FINISH   // write entry, hand result to output register
    } t_state;

    t_state              r_state;
    t_op                 r_op;
    logic [KEY_W-1:0]    r_key;
    logic [SIZE_W-1:0]   r_size;

    // slot sweep: address issue stage and registered read stage
    logic [IW-1:0]       r_idx;
    logic                r_issue;
    logic                r_rd_vld;
    logic [IW-1:0]       r_rd_idx;

    // best candidate so far: most recent match on lookup, least recent on insert
    logic                r_found;
    logic [IW-1:0]       r_best_idx;
    logic [IW-1:0]       r_best_rank;
    logic [SIZE_W-1:0]   r_best_size;
    logic [KEY_W-1:0]    r_best_key;
    logic                r_have_free;
    logic [IW-1:0]       r_free_idx;

    logic [CAPACITY-1:0] r_valid;
    logic [CW-1:0]       r_count;

    logic                r_out_valid;
    logic                r_out_hit;
    logic                r_out_evicted;
    logic [IW-1:0]       r_out_idx;
    logic [SIZE_W-1:0]   r_out_size;
    logic [KEY_W-1:0]    r_out_evkey;

    // slot memories, one read and one write port each
    logic [KEY_W-1:0]    mem_key  [CAPACITY];
    logic [SIZE_W-1:0]   mem_size [CAPACITY];
    logic [IW-1:0]       mem_rank [CAPACITY];
    logic [KEY_W-1:0]    r_key_q;
    logic [SIZE_W-1:0]   r_size_q;
    logic [IW-1:0]       r_rank_q;

    logic                full;
    logic                in_beat;
    logic                out_free;
    logic                rd_slot_valid;
    logic                key_match;
    logic                rank_lt;
    logic                rank_gt;
    logic                take;
    logic                free_take;
    logic                found_n;
    logic                sweep_end;
    logic [IW-1:0]       target;
    logic                age_hit;
    logic                age_bump;
    logic                rank_wr_en;
    logic [IW-1:0]       rank_wr_data;
    logic                kv_wr_en;
    logic [IW+SLOT_W-1:0] slot_ext;

    assign full          = (r_count == CW'(CAPACITY));
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign rd_slot_valid = r_valid[r_rd_idx];
    assign sweep_end     = r_rd_vld && (r_rd_idx == LAST);

    // the shared compare unit: one key compare and one rank compare per cycle
    assign key_match = (r_key_q == r_key);
    assign rank_lt   = (r_rank_q < r_best_rank);
    assign rank_gt   = !rank_lt && (r_rank_q != r_best_rank);

    always_comb begin
        if (r_op == OP_LOOKUP) begin
            take = rd_slot_valid && key_match && (!r_found || rank_lt);
        end else begin
            take = rd_slot_valid && (!r_found || rank_gt);
        end
    end

    assign free_take = !rd_slot_valid && !r_have_free;
    assign found_n   = r_found || (r_rd_vld && take);

    // insert with room goes to the first free slot, else to the best candidate
    assign target = (r_op == OP_INSERT && !full) ? r_free_idx : r_best_idx;

    // aging: promoted/filled slot to zero, more recent ones (all valid ones on insert) one step less recent
    assign age_hit      = (r_rd_idx == target);
    assign age_bump     = rd_slot_valid && (r_op == OP_INSERT || rank_lt);
    assign rank_wr_en   = (r_state == ST_AGE) && r_rd_vld && (age_hit || age_bump);
    assign rank_wr_data = age_hit ? '0 : r_rank_q + 1'b1;

    assign kv_wr_en = (r_state == ST_FINISH) && out_free && (r_op == OP_INSERT);

    always_ff @(posedge i_clk) begin
        r_key_q  <= mem_key[r_idx];
        r_size_q <= mem_size[r_idx];
        r_rank_q <= mem_rank[r_idx];
        if (rank_wr_en) begin
            mem_rank[r_rd_idx] <= rank_wr_data;
        end
        if (kv_wr_en) begin
            mem_key[target]  <= r_key;
            mem_size[target] <= r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
        end else begin
            // finish reloads the output register itself
            if (r_out_valid && m_axis_tready && r_state != ST_FINISH) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_op        <= t_op'(s_axis_tuser[0]);
                        r_key       <= s_axis_tdata[KEY_W-1:0];
                        r_size      <= s_axis_tdata[KEY_W+SIZE_W-1:KEY_W];
                        r_idx       <= '0;
                        r_issue     <= 1'b1;
                        r_rd_vld    <= 1'b0;
                        r_found     <= 1'b0;
                        r_have_free <= 1'b0;
                        r_state     <= ST_SCAN;
                    end
                end

                ST_SCAN, ST_AGE: begin
                    // issue is already off when the sweep ends
                    r_rd_vld <= r_issue;
                    r_rd_idx <= r_idx;
                    if (r_issue) begin
                        if (r_idx == LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end

                    if (r_state == ST_SCAN) begin
                        if (r_rd_vld && take) begin
                            r_found     <= 1'b1;
                            r_best_idx  <= r_rd_idx;
                            r_best_rank <= r_rank_q;
                            r_best_size <= r_size_q;
                            r_best_key  <= r_key_q;
                        end
                        if (r_rd_vld && free_take) begin
                            r_have_free <= 1'b1;
                            r_free_idx  <= r_rd_idx;
                        end
                        if (sweep_end) begin
                            if (r_op == OP_LOOKUP && !found_n) begin
                                r_state <= ST_FINISH;
                            end else begin
                                r_idx    <= '0;
                                r_issue  <= 1'b1;
                                r_state  <= ST_AGE;
                            end
                        end
                    end else if (sweep_end) begin
                        r_state <= ST_FINISH;
                    end
                end

                ST_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_op == OP_LOOKUP) begin
                            r_out_hit     <= r_found;
                            r_out_idx     <= r_found ? r_best_idx : '0;
                            r_out_size    <= r_found ? r_best_size : '0;
                            r_out_evicted <= 1'b0;
                            r_out_evkey   <= '0;
                        end else begin
                            r_out_hit       <= 1'b0;
                            r_out_idx       <= target;
                            r_out_size      <= '0;
                            r_out_evicted   <= full;
                            r_out_evkey     <= full ? r_best_key : '0;
                            r_valid[target] <= 1'b1;
                            if (!full) begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                        r_state <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // slot reported on its 4-bit field whatever the index width
    assign slot_ext      = {{SLOT_W{1'b0}}, r_out_idx};
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_evkey, r_out_size, slot_ext[SLOT_W-1:0]};
    assign m_axis_tuser  = {r_out_evicted, r_out_hit};

    // fill count tracks the valid bits
    `LKC_ASSERT_NOW(a_count_matches_valid, 1'b1, r_count == CW'($countones(r_valid)), "fill count out of step with valid bits")
    // an eviction only happens on a full store, which then stays full
    `LKC_ASSERT_NOW(a_evict_when_full, r_out_valid && r_out_evicted, full, "eviction reported while store not full")
    // a reported hit points at a live slot
    `LKC_ASSERT_NOW(a_hit_slot_valid, r_out_valid && r_out_hit, r_valid[r_out_idx], "hit reported on an empty slot")
    // an insert leaves its target slot valid
    `LKC_ASSERT_NEXT(a_insert_fills, kv_wr_en, r_valid[$past(target)], "insert target not marked valid")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lkc_pkg::*;

    localparam int SLOTS        = DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 1850;
    localparam int DRAIN_CYCLES = 4 * (2 * SLOTS + 4);
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 700;

    typedef struct packed {
        t_op                op;
        logic [KEY_W-1:0]   key;
        logic [SIZE_W-1:0]  size;
    } t_lru_req;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [SIZE_W-1:0]  stored_size;
        logic               evicted;
        logic [KEY_W-1:0]   evicted_key;
    } t_lru_reply;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // key[63:0], entry_size[95:64]
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;   // operation[0]

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // slot[3:0], stored_size[35:4], evicted_key[99:36]
    logic [M_TUSER_W-1:0] m_axis_tuser;         // hit[0], evicted[1]

    lru_keyed_entry_cache dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // shadow copy of the tag store
    logic              tag_valid [SLOTS];
    logic [KEY_W-1:0]  tag_key   [SLOTS];
    logic [SIZE_W-1:0] tag_size  [SLOTS];
    int                tag_rank  [SLOTS];
    int                tag_count;

    t_lru_req   requests_todo[$];
    t_lru_reply replies_due[$];

    int cyc;
    int send_gap;
    int stall_left;
    int hold_left;
    bit hold_done;
    int n_results;
    int n_mismatch;
    int n_lookups, n_hits, n_inserts, n_evictions;

    // computes the reply of one request and updates the shadow store
    function automatic t_lru_reply lru_access(t_lru_req rq);
        t_lru_reply r;
        bit         found;
        int         best;
        int         limit;
        int         victim;
        bit         have;
        r = '0;
        if (rq.op == OP_LOOKUP) begin
            n_lookups++;
            found = 0;
            best  = 0;
            // smallest rank wins among duplicate keys
            for (int i = 0; i < SLOTS; i++) begin
                if (tag_valid[i] && tag_key[i] == rq.key &&
                    (!found || tag_rank[i] < tag_rank[best])) begin
                    best  = i;
                    found = 1;
                end
            end
            if (found) begin
                n_hits++;
                limit = tag_rank[best];
                for (int i = 0; i < SLOTS; i++)
                    if (tag_valid[i] && tag_rank[i] < limit) tag_rank[i]++;
                tag_rank[best]  = 0;
                r.hit           = 1'b1;
                r.slot          = best[SLOT_W-1:0];
                r.stored_size   = tag_size[best];
            end
        end else begin
            n_inserts++;
            have   = 0;
            victim = 0;
            // full store: drop the least recent entry and reuse its slot
            if (tag_count >= SLOTS) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tag_valid[i] && (!have || tag_rank[i] > tag_rank[victim])) begin
                        victim = i;
                        have   = 1;
                    end
                end
                if (have) begin
                    n_evictions++;
                    r.evicted         = 1'b1;
                    r.evicted_key     = tag_key[victim];
                    tag_valid[victim] = 1'b0;
                    tag_count--;
                end
            end
            // otherwise the lowest free slot
            if (!have) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!have && !tag_valid[i]) begin
                        victim = i;
                        have   = 1;
                    end
                end
            end
            if (have) begin
                for (int i = 0; i < SLOTS; i++)
                    if (tag_valid[i]) tag_rank[i]++;
                tag_valid[victim] = 1'b1;
                tag_key[victim]   = rq.key;
                tag_size[victim]  = rq.size;
                tag_rank[victim]  = 0;
                tag_count++;
                r.slot = victim[SLOT_W-1:0];
            end
        end
        return r;
    endfunction

    // idle length: mostly short, a few long, none during periodic back-to-back stretches
    function automatic int pick_gap();
        int r;
        if ((cyc / 1000) % 4 == 1) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_req(t_op op, logic [KEY_W-1:0] key, logic [SIZE_W-1:0] size);
        t_lru_req rq;
        rq.op   = op;
        rq.key  = key;
        rq.size = size;
        requests_todo.push_back(rq);
    endtask

    always @(posedge i_clk) cyc <= cyc + 1;

    // sender: one beat per request, random gaps after each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      = 0;
        end else if (!(s_axis_tvalid && !s_axis_tready)) begin
            if (s_axis_tvalid) begin
                replies_due.push_back(lru_access(requests_todo.pop_front()));
                send_gap = pick_gap();
            end
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (requests_todo.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {requests_todo[0].size, requests_todo[0].key};
                s_axis_tuser  <= requests_todo[0].op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, once, so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_results >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver ready with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    = 0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 70) begin
            m_axis_tready <= 1'b1;
        end else begin
            stall_left = pick_gap();
            m_axis_tready <= (stall_left == 0);
        end
    end

    // monitor: every accepted result beat against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_lru_reply got;
        t_lru_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.slot        = m_axis_tdata[3:0];
            got.stored_size = m_axis_tdata[35:4];
            got.evicted_key = m_axis_tdata[99:36];
            got.hit         = m_axis_tuser[0];
            got.evicted     = m_axis_tuser[1];
            n_results <= n_results + 1;
            if (replies_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("t=%0t unexpected result beat: hit=%0b slot=%0d size=%h ev=%0b evkey=%h",
                             $time, got.hit, got.slot, got.stored_size, got.evicted,
                             got.evicted_key);
            end else begin
                want = replies_due.pop_front();
                if (got.hit !== want.hit || got.slot !== want.slot ||
                    got.stored_size !== want.stored_size || got.evicted !== want.evicted ||
                    got.evicted_key !== want.evicted_key) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("t=%0t result %0d mismatch", $time, n_results);
                        $display("  expected hit=%0b slot=%0d size=%h ev=%0b evkey=%h",
                                 want.hit, want.slot, want.stored_size, want.evicted,
                                 want.evicted_key);
                        $display("  actual   hit=%0b slot=%0d size=%h ev=%0b evkey=%h",
                                 got.hit, got.slot, got.stored_size, got.evicted,
                                 got.evicted_key);
                    end
                end
            end
        end
    end

    // run limit, far above the slowest legal run
    initial begin
        #(64'd12_000_000);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        logic [KEY_W-1:0] key_pool [32];
        int               pool_top;
        logic [KEY_W-1:0] k;
        logic [SIZE_W-1:0] sz;
        t_op              op;

        for (int i = 0; i < SLOTS; i++) begin
            tag_valid[i] = 1'b0;
            tag_key[i]   = '0;
            tag_size[i]  = '0;
            tag_rank[i]  = 0;
        end
        tag_count = 0;

        // directed: empty miss, extreme keys and sizes, duplicates, fill, eviction
        push_req(OP_LOOKUP, '0, '0);
        push_req(OP_INSERT, '0, '0);
        push_req(OP_INSERT, '1, '1);
        push_req(OP_INSERT, '0, 32'h1234_5678);
        push_req(OP_LOOKUP, '0, '1);
        push_req(OP_LOOKUP, '1, '0);
        push_req(OP_LOOKUP, 64'h0000_0000_0000_dead, '0);
        for (int i = 0; i < SLOTS - 3; i++)
            push_req(OP_INSERT, 64'h5a5a_0000_0000_0100 + i, 32'h100 * (i + 1));
        push_req(OP_INSERT, 64'h8000_0000_0000_0001, 32'h8000_0000);
        push_req(OP_LOOKUP, '0, '0);
        push_req(OP_INSERT, '1, '0);

        // random: lookups and inserts over a key pool whose live range drifts,
        // so hits, misses, duplicates and evictions all keep happening
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 32; i++) key_pool[i] = {$urandom, $urandom};
        pool_top = 7;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) pool_top = $urandom_range(3, 31);
            op = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_LOOKUP;
            if ($urandom_range(0, 99) < ((op == OP_LOOKUP) ? 85 : 90))
                k = key_pool[$urandom_range(0, pool_top)];
            else
                k = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0:       sz = '0;
                1:       sz = '1;
                default: sz = $urandom;
            endcase
            push_req(op, k, sz);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_todo.size() != 0 || replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        n_mismatch += replies_due.size();
        $display("covered %0d lookups (%0d hits, %0d misses) and %0d inserts (%0d evictions)",
                 n_lookups, n_hits, n_lookups - n_hits, n_inserts, n_evictions);
        $display("with random gaps on both sides and one %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (n_mismatch == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
